// ===== rtl/core/frame_header_crc_verifier_unit_defines.svh =====
// assertion macros shared by the verifier rtl
`ifndef FRAME_HEADER_CRC_VERIFIER_UNIT_DEFINES_SVH
`define FRAME_HEADER_CRC_VERIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// expression must hold at every edge out of reset
`define FHCV_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("fhcv assertion failed");

// consequent must hold in the same cycle as the antecedent
`define FHCV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fhcv assertion failed");

// consequent must hold in the cycle after the antecedent
`define FHCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fhcv assertion failed");

`else

`define FHCV_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define FHCV_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FHCV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/fhcv_pkg.sv =====
package fhcv_pkg;

    localparam int HEADER_BYTES    = 40;
    localparam int MAX_FRAME_BYTES = 128;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] PROTO_VERSION = 16'd1;
    localparam logic [31:0] CRC_POLY      = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

    // frame type codes
    localparam logic [15:0] KIND_HELLO        = 16'd1;
    localparam logic [15:0] KIND_ACK          = 16'd2;
    localparam logic [15:0] KIND_READ         = 16'd3;
    localparam logic [15:0] KIND_WRITE        = 16'd4;
    localparam logic [15:0] KIND_MEM_RESP     = 16'd5;
    localparam logic [15:0] KIND_CNT_SNAPSHOT = 16'd6;
    localparam logic [15:0] KIND_CNT_RESP     = 16'd7;
    localparam logic [15:0] KIND_ERROR        = 16'd8;

    typedef enum logic [3:0] {
        VERDICT_OK         = 4'd0,
        VERDICT_RX_LENGTH  = 4'd1,
        VERDICT_MAGIC      = 4'd2,
        VERDICT_VERSION    = 4'd3,
        VERDICT_KIND       = 4'd4,
        VERDICT_LENGTH     = 4'd5,
        VERDICT_FLAGS      = 4'd6,
        VERDICT_RESERVED   = 4'd7,
        VERDICT_REQUEST    = 4'd8,
        VERDICT_CLIENT     = 4'd9,
        VERDICT_MISMATCH   = 4'd10,
        VERDICT_WRONG_KIND = 4'd11,
        VERDICT_CRC        = 4'd12
    } verdict_t;

    typedef enum logic [3:0] {
        FIELD_MAGIC,
        FIELD_VERSION,
        FIELD_KIND,
        FIELD_LENGTH,
        FIELD_FLAGS,
        FIELD_REQUEST,
        FIELD_CLIENT,
        FIELD_CHECKSUM,
        FIELD_RESERVED,
        FIELD_BODY
    } field_t;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        field_t     field;
        logic [2:0] lane;
        logic [8:0] received;
    } item_t;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        return crc;
    endfunction

    // "SLT2"
    function automatic logic [7:0] magic_byte(input logic [1:0] lane);
        logic [7:0] value;
        unique case (lane)
            2'd0:    value = 8'h53;
            2'd1:    value = 8'h4C;
            2'd2:    value = 8'h54;
            default: value = 8'h32;
        endcase
        return value;
    endfunction

    function automatic logic [7:0] kind_length(input logic [15:0] kind);
        logic [7:0] value;
        unique case (kind)
            KIND_HELLO:        value = 8'd72;
            KIND_ACK:          value = 8'd88;
            KIND_READ:         value = 8'd128;
            KIND_WRITE:        value = 8'd128;
            KIND_MEM_RESP:     value = 8'd128;
            KIND_CNT_SNAPSHOT: value = 8'd48;
            KIND_CNT_RESP:     value = 8'd112;
            KIND_ERROR:        value = 8'd56;
            default:           value = 8'd0;
        endcase
        return value;
    endfunction

    function automatic verdict_t judge(
        input logic [8:0]  received,
        input logic        magic_ok,
        input logic [15:0] version,
        input logic [15:0] kind,
        input logic [31:0] length,
        input logic        flags_nonzero,
        input logic        reserved_nonzero,
        input logic [63:0] request,
        input logic [63:0] client,
        input logic [31:0] received_crc,
        input logic [31:0] crc,
        input logic [3:0]  want_kind
    );
        logic [7:0] need;
        need = kind_length(kind);
        if (received < 9'(HEADER_BYTES) || received > 9'(MAX_FRAME_BYTES))
            return VERDICT_RX_LENGTH;
        if (!magic_ok)
            return VERDICT_MAGIC;
        if (version != PROTO_VERSION)
            return VERDICT_VERSION;
        if (need == 8'd0)
            return VERDICT_KIND;
        if (length != {24'd0, need} || length < 32'(HEADER_BYTES)
                || length > 32'(MAX_FRAME_BYTES))
            return VERDICT_LENGTH;
        if (flags_nonzero)
            return VERDICT_FLAGS;
        if (reserved_nonzero)
            return VERDICT_RESERVED;
        if (request == 64'd0)
            return VERDICT_REQUEST;
        if ((kind == KIND_HELLO) ? (client != 64'd0) : (client == 64'd0))
            return VERDICT_CLIENT;
        if ({23'd0, received} != length)
            return VERDICT_MISMATCH;
        if (want_kind != 4'd0 && kind != {12'd0, want_kind})
            return VERDICT_WRONG_KIND;
        if (received_crc != crc)
            return VERDICT_CRC;
        return VERDICT_OK;
    endfunction

endpackage

// ===== rtl/core/fhcv_front.sv =====
`include "frame_header_crc_verifier_unit_defines.svh"

module fhcv_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_frame_byte,
    input  logic              s_last_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output fhcv_pkg::item_t   push_item
);
    import fhcv_pkg::*;

    logic [7:0] position_reg;
    logic [7:0] position_next;
    logic       accept;
    field_t     field;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && s_ready;

    always_comb begin
        if (position_reg < 8'd4)
            field = FIELD_MAGIC;
        else if (position_reg < 8'd6)
            field = FIELD_VERSION;
        else if (position_reg < 8'd8)
            field = FIELD_KIND;
        else if (position_reg < 8'd12)
            field = FIELD_LENGTH;
        else if (position_reg < 8'd16)
            field = FIELD_FLAGS;
        else if (position_reg < 8'd24)
            field = FIELD_REQUEST;
        else if (position_reg < 8'd32)
            field = FIELD_CLIENT;
        else if (position_reg < 8'd36)
            field = FIELD_CHECKSUM;
        else if (position_reg < 8'(HEADER_BYTES))
            field = FIELD_RESERVED;
        else
            field = FIELD_BODY;
    end

    // all header fields are aligned, so the low position bits give the byte lane
    always_comb begin
        push_item.frame_byte = s_frame_byte;
        push_item.last_byte  = s_last_byte;
        push_item.field      = field;
        push_item.lane       = position_reg[2:0];
        push_item.received   = {1'b0, position_reg} + 9'd1;
    end

    // saturating byte count, back to zero after the last byte
    always_comb begin
        position_next = position_reg;
        if (accept) begin
            if (s_last_byte)
                position_next = 8'd0;
            else if (position_reg != 8'hFF)
                position_next = position_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= 8'd0;
        end else begin
            position_reg <= position_next;
        end
    end

    `FHCV_ASSERT_NEXT(a_position_restarts, aclk, aresetn, accept && s_last_byte, position_reg == 8'd0)

endmodule

// ===== rtl/core/fhcv_queue.sv =====
`include "frame_header_crc_verifier_unit_defines.svh"

module fhcv_queue #(
    parameter int DEPTH = fhcv_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  fhcv_pkg::item_t   push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output fhcv_pkg::item_t   pop_item
);
    import fhcv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               wr_en;
    logic               rd_en;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign wr_en      = push_valid && push_ready;
    assign rd_en      = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_next;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `FHCV_ASSERT_ALWAYS(a_count_in_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `FHCV_ASSERT_NEXT(a_count_grows, aclk, aresetn, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== rtl/core/fhcv_back.sv =====
`include "frame_header_crc_verifier_unit_defines.svh"

module fhcv_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [3:0]        want_kind,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  fhcv_pkg::item_t   pop_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_verdict,
    output logic [15:0]       m_frame_kind,
    output logic [31:0]       m_header_length,
    output logic [63:0]       m_request_tag,
    output logic [63:0]       m_client_tag
);
    import fhcv_pkg::*;

    logic [31:0] crc_reg,          crc_next;
    logic        magic_ok_reg,     magic_ok_next;
    logic [15:0] version_reg,      version_next;
    logic [15:0] kind_reg,         kind_next;
    logic [31:0] length_reg,       length_next;
    logic        flags_nz_reg,     flags_nz_next;
    logic        reserved_nz_reg,  reserved_nz_next;
    logic [63:0] request_reg,      request_next;
    logic [63:0] client_reg,       client_next;
    logic [31:0] rx_crc_reg,       rx_crc_next;

    logic        out_valid_reg;
    verdict_t    out_verdict_reg;
    logic [15:0] out_kind_reg;
    logic [31:0] out_length_reg;
    logic [63:0] out_request_reg;
    logic [63:0] out_client_reg;

    logic        out_free;
    logic        pop;
    logic        pop_last;
    logic [7:0]  b;
    logic [5:0]  shift;
    logic [7:0]  crc_data;
    verdict_t    verdict;

    assign out_free  = !out_valid_reg || m_ready;
    // a last byte waits until the result register can take its verdict
    assign pop_ready = !pop_item.last_byte || out_free;
    assign pop       = pop_valid && pop_ready;
    assign pop_last  = pop && pop_item.last_byte;

    assign b        = pop_item.frame_byte;
    assign shift    = {pop_item.lane, 3'b000};
    // checksum bytes enter the crc as zero
    assign crc_data = (pop_item.field == FIELD_CHECKSUM) ? 8'd0 : b;

    always_comb begin
        crc_next         = crc32c_byte(crc_reg, crc_data);
        magic_ok_next    = magic_ok_reg;
        version_next     = version_reg;
        kind_next        = kind_reg;
        length_next      = length_reg;
        flags_nz_next    = flags_nz_reg;
        reserved_nz_next = reserved_nz_reg;
        request_next     = request_reg;
        client_next      = client_reg;
        rx_crc_next      = rx_crc_reg;
        unique case (pop_item.field)
            FIELD_MAGIC:
                if (b != magic_byte(pop_item.lane[1:0]))
                    magic_ok_next = 1'b0;
            FIELD_VERSION:
                version_next = version_reg | ({8'd0, b} << {pop_item.lane[0], 3'b000});
            FIELD_KIND:
                kind_next = kind_reg | ({8'd0, b} << {pop_item.lane[0], 3'b000});
            FIELD_LENGTH:
                length_next = length_reg | ({24'd0, b} << {pop_item.lane[1:0], 3'b000});
            FIELD_FLAGS:
                if (b != 8'd0)
                    flags_nz_next = 1'b1;
            FIELD_REQUEST:
                request_next = request_reg | ({56'd0, b} << shift);
            FIELD_CLIENT:
                client_next = client_reg | ({56'd0, b} << shift);
            FIELD_CHECKSUM:
                rx_crc_next = rx_crc_reg | ({24'd0, b} << {pop_item.lane[1:0], 3'b000});
            FIELD_RESERVED:
                if (b != 8'd0)
                    reserved_nz_next = 1'b1;
            default: ;
        endcase
    end

    assign verdict = judge(pop_item.received, magic_ok_next, version_next, kind_next,
                           length_next, flags_nz_next, reserved_nz_next, request_next,
                           client_next, rx_crc_next, crc_next, want_kind);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg         <= CRC_INIT;
            magic_ok_reg    <= 1'b1;
            version_reg     <= '0;
            kind_reg        <= '0;
            length_reg      <= '0;
            flags_nz_reg    <= 1'b0;
            reserved_nz_reg <= 1'b0;
            request_reg     <= '0;
            client_reg      <= '0;
            rx_crc_reg      <= '0;
        end else if (pop_last) begin
            crc_reg         <= CRC_INIT;
            magic_ok_reg    <= 1'b1;
            version_reg     <= '0;
            kind_reg        <= '0;
            length_reg      <= '0;
            flags_nz_reg    <= 1'b0;
            reserved_nz_reg <= 1'b0;
            request_reg     <= '0;
            client_reg      <= '0;
            rx_crc_reg      <= '0;
        end else if (pop) begin
            crc_reg         <= crc_next;
            magic_ok_reg    <= magic_ok_next;
            version_reg     <= version_next;
            kind_reg        <= kind_next;
            length_reg      <= length_next;
            flags_nz_reg    <= flags_nz_next;
            reserved_nz_reg <= reserved_nz_next;
            request_reg     <= request_next;
            client_reg      <= client_next;
            rx_crc_reg      <= rx_crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_last) begin
            out_verdict_reg <= verdict;
            out_kind_reg    <= kind_next;
            out_length_reg  <= length_next;
            out_request_reg <= request_next;
            out_client_reg  <= client_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_verdict       = out_verdict_reg;
    assign m_frame_kind    = out_kind_reg;
    assign m_header_length = out_length_reg;
    assign m_request_tag   = out_request_reg;
    assign m_client_tag    = out_client_reg;

    `FHCV_ASSERT_IMPLY(a_result_from_last, aclk, aresetn, $rose(out_valid_reg), $past(pop_last))

endmodule

// ===== rtl/core/frame_header_crc_verifier_unit.sv =====
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+------------------------------------------
// s_        | in        | s_valid / s_ready       | s_frame_byte, s_last_byte
// m_        | out       | m_valid / m_ready       | m_verdict, m_frame_kind, m_header_length,
//           |           |                         | m_request_tag, m_client_tag
// cfg_      | in        | cfg_valid / cfg_ready   | cfg_data (required frame type)
//
// one byte per cycle unless a held result stalls; back-end bytewise crc32c sets that rate
// each last byte passes the byte queue before its verdict is registered in the result register
// a byte queue of QUEUE_DEPTH entries parts the byte counter from crc and field capture
// a held result stalls the next last byte and bytes behind it; earlier ones keep flowing
// reset is synchronous and clears the type filter to zero; cfg_ready is always high
`include "frame_header_crc_verifier_unit_defines.svh"

module frame_header_crc_verifier_unit #(
    parameter int QUEUE_DEPTH = fhcv_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_verdict,
    output logic [15:0] m_frame_kind,
    output logic [31:0] m_header_length,
    output logic [63:0] m_request_tag,
    output logic [63:0] m_client_tag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import fhcv_pkg::*;

    logic [3:0] want_kind_reg;
    logic       push_valid;
    logic       push_ready;
    item_t      push_item;
    logic       pop_valid;
    logic       pop_ready;
    item_t      pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            want_kind_reg <= 4'd0;
        end else if (cfg_valid && cfg_ready) begin
            want_kind_reg <= cfg_data;
        end
    end

    fhcv_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_byte (s_frame_byte),
        .s_last_byte  (s_last_byte),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    fhcv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fhcv_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .want_kind       (want_kind_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_item        (pop_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_frame_kind    (m_frame_kind),
        .m_header_length (m_header_length),
        .m_request_tag   (m_request_tag),
        .m_client_tag    (m_client_tag)
    );

endmodule

// ===== test/frame_header_crc_verifier_unit_tb.sv =====
`timescale 1ns / 1ps

module frame_header_crc_verifier_unit_tb;
    import fhcv_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [31:0] MAGIC_WORD    = "SLT2";
    localparam logic [15:0] KIND_BEYOND   = 16'd9;
    localparam logic [15:0] KIND_ALL_ONES = 16'hFFFF;

    typedef struct {
        verdict_t    verdict;
        logic [15:0] kind;
        logic [31:0] length;
        logic [63:0] request;
        logic [63:0] client;
    } frame_verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_frame_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_verdict;
    logic [15:0] m_frame_kind;
    logic [31:0] m_header_length;
    logic [63:0] m_request_tag;
    logic [63:0] m_client_tag;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = 4'd0;

    frame_header_crc_verifier_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_frame_kind   (m_frame_kind),
        .m_header_length(m_header_length),
        .m_request_tag  (m_request_tag),
        .m_client_tag   (m_client_tag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // verdict predictor state
    logic [3:0]  required_type;
    logic [7:0]  seen_count;
    logic [31:0] crc_acc;
    logic        magic_good;
    logic [15:0] version_acc;
    logic [15:0] kind_acc;
    logic [31:0] length_acc;
    logic        flags_seen;
    logic        reserved_seen;
    logic [63:0] request_acc;
    logic [63:0] client_acc;
    logic [31:0] crc_field;

    frame_verdict_t expected_verdicts[$];
    frame_verdict_t want;
    logic [7:0]     frame_bytes[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [31:0] crc32c_next(input logic [31:0] acc, input logic [7:0] data);
        logic [31:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ data[k])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic int required_length(input logic [15:0] kind);
        case (kind) inside
            KIND_HELLO:                           return 72;
            KIND_ACK:                             return 88;
            KIND_READ, KIND_WRITE, KIND_MEM_RESP: return 128;
            KIND_CNT_SNAPSHOT:                    return 48;
            KIND_CNT_RESP:                        return 112;
            KIND_ERROR:                           return 56;
            default:                              return 0;
        endcase
    endfunction

    function automatic void clear_frame_state();
        seen_count    = 8'd0;
        crc_acc       = CRC_INIT;
        magic_good    = 1'b1;
        version_acc   = 16'd0;
        kind_acc      = 16'd0;
        length_acc    = 32'd0;
        flags_seen    = 1'b0;
        reserved_seen = 1'b0;
        request_acc   = 64'd0;
        client_acc    = 64'd0;
        crc_field     = 32'd0;
    endfunction

    function automatic verdict_t rule_verdict(input int received);
        int need;
        need = required_length(kind_acc);
        if (received < HEADER_BYTES || received > MAX_FRAME_BYTES)
            return VERDICT_RX_LENGTH;
        if (!magic_good)
            return VERDICT_MAGIC;
        if (version_acc != PROTO_VERSION)
            return VERDICT_VERSION;
        if (need == 0)
            return VERDICT_KIND;
        if (length_acc != 32'(need))
            return VERDICT_LENGTH;
        if (flags_seen)
            return VERDICT_FLAGS;
        if (reserved_seen)
            return VERDICT_RESERVED;
        if (request_acc == 64'd0)
            return VERDICT_REQUEST;
        if ((kind_acc == KIND_HELLO) ? (client_acc != 64'd0) : (client_acc == 64'd0))
            return VERDICT_CLIENT;
        if (32'(received) != length_acc)
            return VERDICT_MISMATCH;
        if (required_type != 4'd0 && kind_acc != {12'd0, required_type})
            return VERDICT_WRONG_KIND;
        if (crc_field != crc_acc)
            return VERDICT_CRC;
        return VERDICT_OK;
    endfunction

    function automatic void track_frame_byte(input logic [7:0] data, input logic last);
        int idx;
        frame_verdict_t v;
        idx = seen_count;
        if (idx < 4) begin
            if (data != MAGIC_WORD[8*(3-idx) +: 8])
                magic_good = 1'b0;
        end else if (idx < 6) begin
            version_acc[8*(idx-4) +: 8] = data;
        end else if (idx < 8) begin
            kind_acc[8*(idx-6) +: 8] = data;
        end else if (idx < 12) begin
            length_acc[8*(idx-8) +: 8] = data;
        end else if (idx < 16) begin
            if (data != 8'd0)
                flags_seen = 1'b1;
        end else if (idx < 24) begin
            request_acc[8*(idx-16) +: 8] = data;
        end else if (idx < 32) begin
            client_acc[8*(idx-24) +: 8] = data;
        end else if (idx < 36) begin
            crc_field[8*(idx-32) +: 8] = data;
        end else if (idx < HEADER_BYTES) begin
            if (data != 8'd0)
                reserved_seen = 1'b1;
        end
        // checksum bytes enter the crc as zero
        crc_acc = crc32c_next(crc_acc, (idx >= 32 && idx < 36) ? 8'h00 : data);
        if (seen_count != 8'hFF)
            seen_count++;
        if (last) begin
            v.verdict = rule_verdict(idx + 1);
            v.kind    = kind_acc;
            v.length  = length_acc;
            v.request = request_acc;
            v.client  = client_acc;
            expected_verdicts.push_back(v);
            clear_frame_state();
        end
    endfunction

    // frame building
    function automatic void put_le(input int offset, input int count, input logic [63:0] value);
        for (int i = 0; i < count; i++) begin
            if (offset + i < frame_bytes.size())
                frame_bytes[offset+i] = value[8*i +: 8];
        end
    endfunction

    function automatic void make_frame(input logic [15:0] kind, input int total);
        logic [63:0] request;
        logic [63:0] client;
        frame_bytes.delete();
        for (int i = 0; i < ((total > HEADER_BYTES) ? total : HEADER_BYTES); i++)
            frame_bytes.push_back(8'($urandom));
        request = {$urandom, $urandom};
        if (request == 64'd0)
            request = 64'd1;
        client = {$urandom, $urandom};
        if (kind == KIND_HELLO)
            client = 64'd0;
        else if (client == 64'd0)
            client = 64'd1;
        for (int i = 0; i < 4; i++)
            frame_bytes[i] = MAGIC_WORD[8*(3-i) +: 8];
        put_le(4, 2, PROTO_VERSION);
        put_le(6, 2, kind);
        put_le(8, 4, required_length(kind));
        put_le(12, 4, 64'd0);
        put_le(16, 8, request);
        put_le(24, 8, client);
        put_le(32, 4, 64'd0);
        put_le(36, 4, 64'd0);
        while (frame_bytes.size() > total)
            void'(frame_bytes.pop_back());
    endfunction

    function automatic void fill_frame(input int total, input logic [7:0] value);
        frame_bytes.delete();
        for (int i = 0; i < total; i++)
            frame_bytes.push_back(value);
    endfunction

    function automatic void seal_crc();
        logic [31:0] acc;
        acc = CRC_INIT;
        for (int i = 0; i < frame_bytes.size(); i++)
            acc = crc32c_next(acc, (i >= 32 && i < 36) ? 8'h00 : frame_bytes[i]);
        put_le(32, 4, acc);
    endfunction

    function automatic void add_random_fault();
        int idx;
        logic [7:0] mask;
        mask = 8'(1 << $urandom_range(7));
        case ($urandom_range(9))
            0: begin
                idx = $urandom_range(3);
                frame_bytes[idx] = frame_bytes[idx] ^ mask;
            end
            1: put_le(4, 2, $urandom_range(65535));
            2: put_le(6, 2, $urandom_range(65535));
            3: begin
                if ($urandom_range(1) == 0)
                    put_le(8, 4, $urandom);
                else
                    put_le(8, 4, required_length(16'($urandom_range(1, 8))));
            end
            4: frame_bytes[12 + $urandom_range(3)] = 8'($urandom_range(1, 255));
            5: frame_bytes[36 + $urandom_range(3)] = 8'($urandom_range(1, 255));
            6: put_le(16, 8, 64'd0);
            7: begin
                if ({frame_bytes[7], frame_bytes[6]} == KIND_HELLO)
                    put_le(24, 8, {$urandom, $urandom} | 64'd1);
                else
                    put_le(24, 8, 64'd0);
            end
            8: put_le(6, 2, $urandom_range(1, 8));
            default: put_le(0, 4, 64'd0);
        endcase
    endfunction

    function automatic logic [15:0] pick_kind();
        case ($urandom_range(3))
            0:       return KIND_CNT_SNAPSHOT;
            1:       return KIND_ERROR;
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // driving
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= data;
        s_last_byte  <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        track_frame_byte(data, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    task automatic send_clean_frame(input logic [15:0] kind);
        make_frame(kind, required_length(kind));
        seal_crc();
        send_frame();
    endtask

    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_type_filter(input logic [3:0] value);
        wait_for_verdicts();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        required_type = value;
    endtask

    // tests
    task automatic test_good_frames();
        send_clean_frame(KIND_HELLO);
        send_clean_frame(KIND_CNT_SNAPSHOT);
    endtask

    // header faults only need a complete header, so most frames stop at 40 bytes
    task automatic test_header_faults();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        frame_bytes[1] = 8'h6C;
        seal_crc();
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        put_le(4, 2, 16'h0100);
        seal_crc();
        send_frame();
        make_frame(KIND_BEYOND, 40);
        put_le(8, 4, 48);
        seal_crc();
        send_frame();
        make_frame(KIND_ALL_ONES, 40);
        put_le(8, 4, 48);
        seal_crc();
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        put_le(8, 4, 56);
        seal_crc();
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        frame_bytes[15] = 8'h80;
        seal_crc();
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        frame_bytes[39] = 8'h01;
        seal_crc();
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        put_le(16, 8, 64'd0);
        seal_crc();
        send_frame();
        // hello must carry no client id, every other type must carry one
        make_frame(KIND_HELLO, 40);
        put_le(24, 8, 64'h8000_0000_0000_0000);
        seal_crc();
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        put_le(24, 8, 64'd0);
        seal_crc();
        send_frame();
        // received length shorter than the header length, then a checksum fault
        make_frame(KIND_CNT_SNAPSHOT, 40);
        seal_crc();
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 48);
        seal_crc();
        frame_bytes[35] = frame_bytes[35] ^ 8'h80;
        send_frame();
    endtask

    task automatic test_frame_extremes();
        fill_frame(1, 8'h00);
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 39);
        send_frame();
        make_frame(KIND_CNT_SNAPSHOT, 40);
        seal_crc();
        send_frame();
        make_frame(KIND_READ, 129);
        seal_crc();
        send_frame();
        // byte counter saturates, length stays out of range
        make_frame(KIND_READ, 260);
        seal_crc();
        send_frame();
    endtask

    task automatic test_type_filter();
        write_type_filter(4'd6);
        send_clean_frame(KIND_CNT_SNAPSHOT);
        send_clean_frame(KIND_ERROR);
        // no frame type can match this one
        write_type_filter(4'd15);
        send_clean_frame(KIND_CNT_SNAPSHOT);
        write_type_filter(4'd8);
        send_clean_frame(KIND_ERROR);
        write_type_filter(4'd0);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        // single-byte frames are all last bytes and pile up behind the held result
        for (int i = 0; i < 12; i++) begin
            fill_frame(1, 8'($urandom));
            send_frame();
        end
        send_clean_frame(KIND_CNT_SNAPSHOT);
        wait_for_verdicts();
    endtask

    task automatic send_random_frame();
        int pick;
        logic [15:0] kind;
        pick = $urandom_range(99);
        kind = pick_kind();
        if (pick < 50) begin
            make_frame(kind, required_length(kind));
            seal_crc();
        end else if (pick < 72) begin
            make_frame(kind, required_length(kind));
            add_random_fault();
            seal_crc();
        end else if (pick < 78) begin
            make_frame(kind, required_length(kind));
            seal_crc();
            frame_bytes[$urandom_range(frame_bytes.size() - 1)] ^= 8'(1 << $urandom_range(7));
        end else if (pick < 85) begin
            make_frame(kind, $urandom_range(HEADER_BYTES, MAX_FRAME_BYTES + 1));
            seal_crc();
        end else if (pick < 93) begin
            make_frame(kind, $urandom_range(1, HEADER_BYTES - 1));
        end else if (pick < 99) begin
            fill_frame($urandom_range(1, 140), 8'd0);
            foreach (frame_bytes[i])
                frame_bytes[i] = 8'($urandom);
        end else begin
            make_frame(kind, $urandom_range(200, 300));
            seal_crc();
        end
        send_frame();
    endtask

    task automatic test_random_traffic(input int sender_gap, input int receiver_gap,
                                       input int byte_goal);
        int first_bytes;
        int first_frames;
        write_type_filter(($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(1, 15)));
        send_idle_pct = sender_gap;
        recv_idle_pct = receiver_gap;
        first_bytes  = bytes_sent;
        first_frames = frames_sent;
        while (bytes_sent - first_bytes < byte_goal || frames_sent - first_frames < 2)
            send_random_frame();
    endtask

    // result side: checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                flag_mismatch("verdict transaction with nothing expected");
            end else begin
                want = expected_verdicts.pop_front();
                if (m_verdict !== want.verdict)
                    flag_mismatch($sformatf("verdict %0d, expected %0d",
                                            m_verdict, want.verdict));
                if (m_frame_kind !== want.kind)
                    flag_mismatch($sformatf("frame kind %h, expected %h",
                                            m_frame_kind, want.kind));
                if (m_header_length !== want.length)
                    flag_mismatch($sformatf("header length %h, expected %h",
                                            m_header_length, want.length));
                if (m_request_tag !== want.request)
                    flag_mismatch($sformatf("request tag %h, expected %h",
                                            m_request_tag, want.request));
                if (m_client_tag !== want.client)
                    flag_mismatch($sformatf("client tag %h, expected %h",
                                            m_client_tag, want.client));
            end
        end
    end

    // result side: random stalls and long hold-offs
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        required_type = 4'd0;
        clear_frame_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_type_filter(4'd0);
        send_idle_pct = 9;
        recv_idle_pct = 67;
        test_good_frames();
        test_header_faults();
        send_idle_pct = 67;
        recv_idle_pct = 9;
        test_frame_extremes();
        test_type_filter();
        test_output_backpressure();
        test_random_traffic(0, 0, 100);
        wait_for_verdicts();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
